### hdl/fir_lp_pkg.sv
// ============================================================================
// fir_lp_pkg
// Shared types and constants of the gated low-pass FIR filter.
// ============================================================================
package fir_lp_pkg;

    // Sample and coefficient formats.
    localparam int DATA_W     = 16;
    localparam int COEF_W     = 16;

    // Coefficient register file: one register per possible tap.
    localparam int NUM_COEF   = 8;
    localparam int COEF_IDX_W = 3;

    // A coefficient below this Q0.16 value is treated as zero (0.001 gate).
    localparam logic [COEF_W-1:0] GATE_MIN = 16'd66;

    // Limits of the signed 16-bit result.
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic        [COEF_W-1:0] coef_t;

endpackage

### hdl/fir_lowpass_with_coef_gate_unit.sv
// ============================================================================
// fir_lowpass_with_coef_gate_unit
// Streaming direct-form FIR low-pass filter with a coefficient gate.
// ============================================================================
// Each input item is a signed 16-bit sample that enters a TAPS-deep window
// kept in a small synchronous memory used as a circular buffer. One result
// item follows per sample: the sum of window[k] * coef_k over the taps whose
// coefficient is 66 (Q0.16) or more, floor-scaled by 2^-16 and saturated to
// signed 16 bits, with tuser flagging a clipped result. A single shared
// multiplier handles one tap per clock unless the pipeline stalls, fed by
// the one read port of the window memory. A new sample can enter as the
// last tap of the current one is issued, even while the previous result
// waits on the output. The window clears at reset through per-entry valid
// bits, with no clearing pass. The user must write coefficients through
// the configuration port only while idle; the block does not enforce this.
// ============================================================================
module fir_lowpass_with_coef_gate_unit #(
    parameter int TAPS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Sample input; tdata: sample_in [15:0].
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [15:0]                           s_tdata,

    // Filtered output; tdata: filtered_out [15:0]; tuser: saturated [0].
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [15:0]                           m_tdata,
    output logic                                  m_tuser,

    // Coefficient write port.
    input  logic                                  cfg_wr_en,
    input  logic [fir_lp_pkg::COEF_IDX_W-1:0]     cfg_index,
    input  logic [fir_lp_pkg::COEF_W-1:0]         cfg_wdata
);

    import fir_lp_pkg::*;

    localparam int PTR_W  = $clog2(TAPS);
    localparam int PROD_W = DATA_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int Q_W    = ACC_W - 16;

    localparam logic [PTR_W-1:0]      LAST_TAP = PTR_W'(TAPS - 1);
    localparam logic [PTR_W-1:0]      DEPTH    = PTR_W'(TAPS);
    localparam logic signed [Q_W-1:0] Q_MAX    = Q_W'(OUT_MAX);
    localparam logic signed [Q_W-1:0] Q_MIN    = Q_W'(OUT_MIN);

    // Coefficient registers and sample window storage.
    coef_t             coef_reg [NUM_COEF];
    logic [DATA_W-1:0] win_mem  [TAPS];
    logic [TAPS-1:0]   win_valid_reg, win_valid_next;

    // Sequencer state.
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tap_reg, tap_next;
    logic              busy_reg, busy_next;
    logic [PTR_W-1:0]  rd_addr;

    // Read stage.
    logic              rd_vld_reg, rd_first_reg, rd_last_reg;
    logic [DATA_W-1:0] rd_raw_reg;
    logic              rd_ok_reg;
    coef_t             rd_coef_reg;

    // Multiply stage.
    logic              prod_vld_reg, prod_first_reg, prod_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    sample_t           mul_a;
    logic signed [PROD_W:0] mul_full;

    // Accumulate stage and finished sum.
    logic signed [ACC_W-1:0] acc_reg, acc_sum;
    logic signed [ACC_W-1:0] sum_reg;
    logic              sum_vld_reg, sum_vld_next;
    logic              sum_move;
    logic              stall;

    // Output register.
    logic              out_vld_reg, out_vld_next;
    logic [15:0]       out_data_reg;
    logic              out_sat_reg;
    logic signed [Q_W-1:0] q_val;
    logic [15:0]       sat_data;
    logic              sat_flag;

    logic              accept;

    // The pipeline holds while a finished sum cannot move to the output.
    assign sum_move = sum_vld_reg && (!out_vld_reg || m_tready);
    assign stall    = sum_vld_reg && !sum_move;

    // A new sample may enter once the last tap of the current one is issued.
    assign s_tready = !stall && (!busy_reg || (tap_reg == LAST_TAP));
    assign accept   = s_tvalid && s_tready;

    // Window address of the sample tap_reg steps older than the newest.
    always_comb
    begin
        if (tap_reg > head_reg)
        begin
            rd_addr = head_reg + DEPTH - tap_reg;
        end
        else
        begin
            rd_addr = head_reg - tap_reg;
        end
    end

    // Next state of the sequencer and window valid bits.
    always_comb
    begin
        head_next      = head_reg;
        tap_next       = tap_reg;
        busy_next      = busy_reg;
        win_valid_next = win_valid_reg;
        if (accept)
        begin
            head_next = (head_reg == LAST_TAP) ? '0 : head_reg + 1'b1;
            win_valid_next[head_next] = 1'b1;
            tap_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg && !stall)
        begin
            if (tap_reg == LAST_TAP)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                tap_next = tap_reg + 1'b1;
            end
        end
    end

    // Gated accumulation of the current product.
    assign acc_sum = (prod_first_reg ? '0 : acc_reg) + ACC_W'(prod_reg);

    always_comb
    begin
        sum_vld_next = sum_vld_reg;
        if (sum_move)
        begin
            sum_vld_next = 1'b0;
        end
        if (!stall && prod_vld_reg && prod_last_reg)
        begin
            sum_vld_next = 1'b1;
        end
    end

    // Floor scaling by 2^-16 and saturation to signed 16 bits.
    assign q_val = sum_reg[ACC_W-1:16];

    always_comb
    begin
        if (q_val > Q_MAX)
        begin
            sat_data = 16'(OUT_MAX);
            sat_flag = 1'b1;
        end
        else if (q_val < Q_MIN)
        begin
            sat_data = 16'(OUT_MIN);
            sat_flag = 1'b1;
        end
        else
        begin
            sat_data = q_val[15:0];
            sat_flag = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (sum_move)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tap_reg       <= '0;
            busy_reg      <= 1'b0;
            win_valid_reg <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            sum_vld_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            head_reg      <= head_next;
            tap_reg       <= tap_next;
            busy_reg      <= busy_next;
            win_valid_reg <= win_valid_next;
            sum_vld_reg   <= sum_vld_next;
            out_vld_reg   <= out_vld_next;
            if (!stall)
            begin
                rd_vld_reg   <= busy_reg;
                prod_vld_reg <= rd_vld_reg;
            end
            if (cfg_wr_en)
            begin
                coef_reg[cfg_index] <= cfg_wdata;
            end
        end
    end

    // Window memory: write the new sample, read one tap per cycle unless stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_mem[head_next] <= s_tdata;
        end
        if (!stall && busy_reg)
        begin
            rd_raw_reg   <= win_mem[rd_addr];
            rd_ok_reg    <= win_valid_reg[rd_addr];
            rd_first_reg <= (tap_reg == '0);
            rd_last_reg  <= (tap_reg == LAST_TAP);
            if (coef_reg[COEF_IDX_W'(tap_reg)] >= GATE_MIN)
            begin
                rd_coef_reg <= coef_reg[COEF_IDX_W'(tap_reg)];
            end
            else
            begin
                rd_coef_reg <= '0;
            end
        end
    end

    // Multiply: an entry never written reads as zero.
    assign mul_a    = rd_ok_reg ? sample_t'(rd_raw_reg) : '0;
    assign mul_full = mul_a * $signed({1'b0, rd_coef_reg});

    always_ff @(posedge clk)
    begin
        if (!stall && rd_vld_reg)
        begin
            prod_reg       <= mul_full[PROD_W-1:0];
            prod_first_reg <= rd_first_reg;
            prod_last_reg  <= rd_last_reg;
        end
    end

    // Accumulator and finished sum.
    always_ff @(posedge clk)
    begin
        if (!stall && prod_vld_reg)
        begin
            acc_reg <= acc_sum;
            if (prod_last_reg)
            begin
                sum_reg <= acc_sum;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (sum_move)
        begin
            out_data_reg <= sat_data;
            out_sat_reg  <= sat_flag;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

### test/tb_fir_lowpass_with_coef_gate_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_fir_lowpass_with_coef_gate_unit
// Self-checking testbench for the gated low-pass FIR filter.
// ============================================================================
// The bench keeps its own copy of the coefficient registers and the sample
// window and computes the expected filter output for every accepted sample.
// A short directed sequence covers reset coefficients, full-scale inputs
// with saturation in both directions, the gate threshold and floor rounding
// of negative sums. Random phases follow, each under a new coefficient set
// written while the filter is idle. The sender works in random bursts and
// the receiver stalls on its own pattern, including one long hold-off.
// ============================================================================
module tb_fir_lowpass_with_coef_gate_unit;

    import fir_lp_pkg::*;

    localparam int TAPS        = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = TAPS + 8;
    localparam int MAX_REPORTS = 10;

    // Coefficient set styles used between phases.
    typedef enum int {
        COEFS_ZERO,
        COEFS_FULL,
        COEFS_RANDOM,
        COEFS_NEAR_GATE,
        COEFS_MIXED,
        COEFS_MODERATE,
        COEFS_GATE_EDGE
    } coef_style_e;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              clipped;
    } filt_out_t;

    // ------------------------------------------------------------------------
    // Filter tracker: mirrors the window and coefficients, holds the
    // expected outputs in order and checks each output item against them.
    // ------------------------------------------------------------------------
    class filter_tracker;
        coef_t     coef[NUM_COEF];
        sample_t   window[TAPS];
        filt_out_t expected_outputs[$];
        int        errors;

        function new();
            foreach (coef[k]) coef[k] = '0;
            foreach (window[k]) window[k] = '0;
            errors = 0;
        endfunction

        function void set_coef(int idx, coef_t value);
            coef[idx] = value;
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        // Shift the sample in and form the gated, floor-scaled, clipped sum.
        function void take_sample(sample_t x);
            longint    acc;
            longint    q;
            filt_out_t res;
            for (int k = TAPS - 1; k > 0; k--)
                window[k] = window[k - 1];
            window[0] = x;
            acc = 0;
            for (int k = 0; k < TAPS; k++)
            begin
                if (coef[k] >= GATE_MIN)
                    acc += longint'(window[k]) * longint'(coef[k]);
            end
            q = acc >>> 16;
            res.clipped = 1'b0;
            if (q > OUT_MAX)
            begin
                q = OUT_MAX;
                res.clipped = 1'b1;
            end
            else if (q < OUT_MIN)
            begin
                q = OUT_MIN;
                res.clipped = 1'b1;
            end
            res.value = q[DATA_W-1:0];
            expected_outputs.push_back(res);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void check_output(logic [DATA_W-1:0] value, logic clipped);
            filt_out_t want;
            if (expected_outputs.size() == 0)
            begin
                report($sformatf("unexpected output %0d clipped %0b",
                                 $signed(value), clipped));
                return;
            end
            want = expected_outputs.pop_front();
            if (value !== want.value)
                report($sformatf("filtered_out expected %0d got %0d",
                                 $signed(want.value), $signed(value)));
            if (clipped !== want.clipped)
                report($sformatf("saturated expected %0b got %0b",
                                 want.clipped, clipped));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;    // sample_in [15:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_W-1:0]     m_tdata;    // filtered_out [15:0]
    logic                  m_tuser;    // saturated [0]
    logic                  cfg_wr_en;
    logic [COEF_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]     cfg_wdata;

    filter_tracker tracker = new();
    int            cycle_count = 0;

    fir_lowpass_with_coef_gate_unit #(
        .TAPS(TAPS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Monitor both handshakes and feed the tracker.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tracker.take_sample(sample_t'(s_tdata));
        if (rst_n && m_tvalid && m_tready)
            tracker.check_output(m_tdata, m_tuser);
    end

    // Receiver: stalls in segments of random style, with one long hold-off
    // once a few hundred outputs have passed.
    initial
    begin : result_sink
        int style;
        int span;
        int seen;
        int hold_left;
        bit hold_done;
        bit ready;
        style     = 0;
        span      = 0;
        seen      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                seen++;
            if (span == 0)
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(16, 120);
            end
            span--;
            if (!hold_done && seen >= 500)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            case (style)
                0:       ready = 1'b1;
                1:       ready = $urandom_range(0, 1);
                2:       ready = ($urandom_range(0, 3) == 0);
                default: ready = ~m_tready;
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                ready = 1'b0;
            end
            m_tready <= ready;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks.
    // ------------------------------------------------------------------------

    // Offer one sample and hold it until it is taken.
    task automatic send_sample(input sample_t value);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop sending and wait until every expected output has arrived.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic coef_t pick_coef(coef_style_e style, int idx);
        case (style)
            COEFS_ZERO:      return '0;
            COEFS_FULL:      return '1;
            COEFS_NEAR_GATE: return coef_t'($urandom_range(60, 72));
            COEFS_MODERATE:  return coef_t'($urandom_range(0, 16384));
            COEFS_GATE_EDGE: return (idx == 0) ? coef_t'(GATE_MIN - 1) :
                                    (idx == 1) ? GATE_MIN : coef_t'(0);
            COEFS_MIXED:
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return coef_t'(GATE_MIN - 1);
                    2:       return GATE_MIN;
                    3:       return '1;
                    default: return coef_t'($urandom_range(0, 65535));
                endcase
            default:         return coef_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Write all eight coefficient registers back to back.
    task automatic write_coef_set(input coef_style_e style);
        coef_t value;
        for (int k = 0; k < NUM_COEF; k++)
        begin
            value = pick_coef(style, k);
            cfg_wr_en <= 1'b1;
            cfg_index <= COEF_IDX_W'(k);
            cfg_wdata <= value;
            tracker.set_coef(k, value);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic sample_t random_sample();
        int pick;
        int v;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return sample_t'($urandom);
        if (pick < 15)
        begin
            case ($urandom_range(0, 4))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                3:       return 16'shFFFF;
                default: return 16'sh0001;
            endcase
        end
        v = int'($urandom_range(0, 512)) - 256;
        return sample_t'(v);
    endfunction

    // Random samples in bursts with random gaps; a single pause midway, when
    // requested, waits for the filter to empty completely.
    task automatic run_random_phase(input int n, input bit pause_midway);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < n; i++)
            begin
                send_sample(random_sample());
                sent++;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                9:          gap = $urandom_range(20, 60);
                default:    gap = $urandom_range(1, 12);
            endcase
            if (pause_midway && sent >= n / 2)
            begin
                pause_midway = 1'b0;
                drain_outputs();
            end
            else if (gap > 0)
                idle_cycles(gap);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        coef_style_e style;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset coefficients gate every tap off, so the output stays zero.
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh3039);
        drain_outputs();

        // Full-scale weights: saturate high, then low as the window turns.
        write_coef_set(COEFS_FULL);
        repeat (3) send_sample(16'sh7FFF);
        repeat (8) send_sample(16'sh8000);
        drain_outputs();

        // Gate threshold on the first two taps; small negative sums
        // round toward minus infinity.
        write_coef_set(COEFS_GATE_EDGE);
        send_sample(16'sd1000);
        send_sample(16'shFFFF);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        drain_outputs();

        // Random phases, each under a fresh coefficient set.
        for (int p = 0; p < 10; p++)
        begin
            style = (p < 6) ? coef_style_e'(p) :
                    coef_style_e'($urandom_range(COEFS_RANDOM, COEFS_MODERATE));
            write_coef_set(style);
            run_random_phase(180, p == 2);
            drain_outputs();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/fir_lp_pkg.sv
hdl/fir_lowpass_with_coef_gate_unit.sv
test/tb_fir_lowpass_with_coef_gate_unit.sv
